// File: design/cpp_pkg.sv
// shared types and constants of the camera perspective projection block
`timescale 1ns / 1ps
`default_nettype none
package cpp_pkg;

    localparam int COORD_W  = 32;
    localparam int COMP_W   = 18;
    localparam int QUOT_W   = 31;
    localparam int SCR_W    = 16;
    localparam int Q_SHIFT  = 16;
    localparam int PROD_W   = COORD_W + COMP_W;
    localparam int SUM_W    = PROD_W + 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [2:0] REG_CAMERA_X      = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y      = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z      = 3'd2;
    localparam logic [2:0] REG_FORWARD_AXIS  = 3'd3;
    localparam logic [2:0] REG_RIGHT_AXIS    = 3'd4;
    localparam logic [2:0] REG_UP_AXIS       = 3'd5;
    localparam logic [2:0] REG_DEPTH_FOCAL   = 3'd6;
    localparam logic [2:0] REG_SCREEN_WINDOW = 3'd7;

    localparam logic [53:0] FORWARD_RESET = 54'd4503599627370496;
    localparam logic [53:0] RIGHT_RESET   = 54'd65536;
    localparam logic [53:0] UP_RESET      = 54'd17179869184;
    localparam logic [63:0] DEPTH_RESET   = 64'd687194767361;
    localparam logic [63:0] WINDOW_RESET  = 64'd288225978112540832;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } vertex_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [31:0]      view_x;
        logic signed [31:0]      view_y;
        logic signed [31:0]      view_z;
        logic signed [SCR_W-1:0] proj_x;
        logic signed [SCR_W-1:0] proj_y;
    } result_t;

    typedef struct packed {
        logic [31:0] camera_x;
        logic [31:0] camera_y;
        logic [31:0] camera_z;
        logic [53:0] forward_axis;
        logic [53:0] right_axis;
        logic [53:0] up_axis;
        logic [63:0] depth_and_focal;
        logic [63:0] screen_window;
    } cfg_t;

    typedef struct packed {
        logic               invalid;
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
    } job_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
    } side_t;

endpackage
`default_nettype wire

// File: design/cpp_fifo.sv
// small register queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cpp_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty)) else $error("queue full and empty at once");
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rd_en) |=> full) else $error("full queue lost an entry");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("queue count past depth");
endmodule
`default_nettype wire

// File: design/cpp_front.sv
// front end: settings registers, request accept and classification
`timescale 1ns / 1ps
`default_nettype none
module cpp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_addr,
    input  wire logic [63:0]      cfg_wdata,
    input  wire logic             push,
    input  wire logic             full,
    input  wire cpp_pkg::vertex_t vertex,
    output logic                  job_wr,
    output cpp_pkg::job_t         job,
    output cpp_pkg::cfg_t         cfg
);
    import cpp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic signed [31:0] near_d, focal;
    logic signed [15:0] lo, hi;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CAMERA_X:      cfg_next.camera_x        = cfg_wdata[31:0];
                REG_CAMERA_Y:      cfg_next.camera_y        = cfg_wdata[31:0];
                REG_CAMERA_Z:      cfg_next.camera_z        = cfg_wdata[31:0];
                REG_FORWARD_AXIS:  cfg_next.forward_axis    = cfg_wdata[53:0];
                REG_RIGHT_AXIS:    cfg_next.right_axis      = cfg_wdata[53:0];
                REG_UP_AXIS:       cfg_next.up_axis         = cfg_wdata[53:0];
                REG_DEPTH_FOCAL:   cfg_next.depth_and_focal = cfg_wdata;
                REG_SCREEN_WINDOW: cfg_next.screen_window   = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{camera_x: 32'd0, camera_y: 32'd0, camera_z: 32'd0,
                         forward_axis: FORWARD_RESET, right_axis: RIGHT_RESET,
                         up_axis: UP_RESET, depth_and_focal: DEPTH_RESET,
                         screen_window: WINDOW_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg    = cfg_reg;
    assign near_d = $signed(cfg_reg.depth_and_focal[31:0]);
    assign focal  = $signed(cfg_reg.depth_and_focal[63:32]);
    assign lo     = $signed(cfg_reg.screen_window[47:32]);
    assign hi     = $signed(cfg_reg.screen_window[63:48]);

    // settings check and camera-relative position, wrapping in 32 bits
    assign job_wr = push && !full;
    assign job    = '{invalid: (near_d <= 0) || (focal <= 0) || (lo > hi),
                      rel_x: vertex.world_x - $signed(cfg_reg.camera_x),
                      rel_y: vertex.world_y - $signed(cfg_reg.camera_y),
                      rel_z: vertex.world_z - $signed(cfg_reg.camera_z)};
endmodule
`default_nettype wire

// File: design/cpp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cpp_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_vld,
    input  wire logic [cpp_pkg::QUOT_W-1:0]  in_div,
    input  wire logic [cpp_pkg::QUOT_W-1:0]  in_num,
    input  wire logic [cpp_pkg::QUOT_W-1:0]  in_rem,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_vld,
    output logic      [cpp_pkg::QUOT_W-1:0]  out_quot,
    output logic      [SIDE_W-1:0]           out_side
);
    import cpp_pkg::*;

    logic              vld_reg  [QUOT_W];
    logic [QUOT_W-1:0] rem_reg  [QUOT_W];
    logic [QUOT_W-1:0] num_reg  [QUOT_W];
    logic [QUOT_W-1:0] quo_reg  [QUOT_W];
    logic [QUOT_W-1:0] div_reg  [QUOT_W];
    logic [SIDE_W-1:0] side_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic              vld_in;
        logic [QUOT_W-1:0] rem_in, num_in, quo_in, div_in;
        logic [SIDE_W-1:0] side_in;
        logic [QUOT_W:0]   trial, diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = in_rem;
            assign num_in  = in_num;
            assign quo_in  = '0;
            assign div_in  = in_div;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign div_in  = div_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, num_in[QUOT_W-1]};
        assign diff  = trial - {1'b0, div_in};
        assign ge    = (trial >= {1'b0, div_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];
                num_reg[k]  <= {num_in[QUOT_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[QUOT_W-2:0], ge};
                div_reg[k]  <= div_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[QUOT_W-1];
    assign out_quot = quo_reg[QUOT_W-1];
    assign out_side = side_reg[QUOT_W-1];
endmodule
`default_nettype wire

// File: design/cpp_back.sv
// back end: view transform, reciprocal, scaling and screen clamp
`timescale 1ns / 1ps
`default_nettype none
module cpp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cpp_pkg::cfg_t cfg,
    input  wire cpp_pkg::job_t job,
    input  wire logic          job_ready,
    output logic               job_pop,
    input  wire logic          pop,
    output logic               empty,
    output cpp_pkg::result_t   result
);
    import cpp_pkg::*;

    logic adv;
    logic signed [31:0] rel [3];
    logic [53:0] axes [3];

    // stage 1: nine products, axis order forward, right, up
    logic s1_vld_reg;
    logic [1:0] s1_stat_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [3][3];

    // stage 2: dot products
    logic s2_vld_reg;
    logic [1:0] s2_stat_reg;
    logic signed [31:0] s2_view_reg [3];
    logic signed [SUM_W-1:0] sum [3];

    // stage 3: depth, overflow check, divider setup
    logic s3_vld_reg;
    side_t s3_side_reg, s3_side;
    logic [QUOT_W-1:0] s3_div_reg, s3_num_reg, s3_rem_reg;
    logic signed [31:0] near_d, depth;
    logic ovf;

    logic dv_vld;
    logic [QUOT_W-1:0] dv_quot;
    side_t dv_side;

    // stage 4: scaling
    logic s4_vld_reg;
    side_t s4_side_reg;
    logic signed [31:0] s4_px_reg, s4_py_reg;
    logic signed [63:0] px, py;

    // stage 5: result register
    logic out_vld_reg;
    result_t out_reg, out_next;
    logic signed [31:0] cx, cy, lo, hi, sx, sy;

    assign adv     = !out_vld_reg || pop;
    assign job_pop = adv && job_ready;

    assign rel[0]  = job.rel_x;
    assign rel[1]  = job.rel_y;
    assign rel[2]  = job.rel_z;
    assign axes[0] = cfg.forward_axis;
    assign axes[1] = cfg.right_axis;
    assign axes[2] = cfg.up_axis;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = SUM_W'(s1_prod_reg[a][0]) + SUM_W'(s1_prod_reg[a][1])
                   + SUM_W'(s1_prod_reg[a][2]);
        end
    end

    assign near_d = $signed(cfg.depth_and_focal[31:0]);
    assign depth  = (s2_view_reg[0] < near_d) ? near_d : s2_view_reg[0];
    // quotient reaches 2^31 exactly when focal >> 15 is at least the depth
    assign ovf    = {15'd0, cfg.depth_and_focal[62:47]} >= depth[QUOT_W-1:0];

    always_comb
    begin
        s3_side.view_x = s2_view_reg[1];
        s3_side.view_y = s2_view_reg[2];
        s3_side.view_z = s2_view_reg[0];
        s3_side.status = s2_stat_reg;
        if (s2_stat_reg == STATUS_OK && ovf)
        begin
            s3_side.status = STATUS_OVERFLOW;
        end
    end

    cpp_div #(.SIDE_W($bits(side_t))) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s3_vld_reg),
        .in_div   (s3_div_reg),
        .in_num   (s3_num_reg),
        .in_rem   (s3_rem_reg),
        .in_side  (s3_side_reg),
        .out_vld  (dv_vld),
        .out_quot (dv_quot),
        .out_side (dv_side)
    );

    assign px = $signed({1'b0, dv_quot}) * dv_side.view_x;
    assign py = $signed({1'b0, dv_quot}) * dv_side.view_y;

    assign cx = 32'(signed'(cfg.screen_window[15:0]));
    assign cy = 32'(signed'(cfg.screen_window[31:16]));
    assign lo = 32'(signed'(cfg.screen_window[47:32]));
    assign hi = 32'(signed'(cfg.screen_window[63:48]));
    assign sx = cx + s4_px_reg;
    assign sy = cy - s4_py_reg;

    always_comb
    begin
        out_next = '0;
        out_next.status = s4_side_reg.status;
        if (s4_side_reg.status == STATUS_OK)
        begin
            out_next.view_x = s4_side_reg.view_x;
            out_next.view_y = s4_side_reg.view_y;
            out_next.view_z = s4_side_reg.view_z;
            priority if (sx < lo) out_next.proj_x = lo[15:0];
            else if (sx > hi)     out_next.proj_x = hi[15:0];
            else                  out_next.proj_x = sx[15:0];
            priority if (sy < lo) out_next.proj_y = lo[15:0];
            else if (sy > hi)     out_next.proj_y = hi[15:0];
            else                  out_next.proj_y = sy[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= job_ready;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= dv_vld;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_stat_reg <= job.invalid ? STATUS_INVALID : STATUS_OK;
            for (int a = 0; a < 3; a++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s1_prod_reg[a][c] <= PROD_W'(rel[c] * $signed(axes[a][c*COMP_W +: COMP_W]));
                end
            end
            s2_stat_reg <= s1_stat_reg;
            for (int a = 0; a < 3; a++)
            begin
                s2_view_reg[a] <= sum[a][Q_SHIFT +: 32];
            end
            s3_side_reg <= s3_side;
            s3_div_reg  <= depth[QUOT_W-1:0];
            s3_num_reg  <= {cfg.depth_and_focal[46:32], 16'd0};
            s3_rem_reg  <= {15'd0, cfg.depth_and_focal[62:47]};
            s4_side_reg <= dv_side;
            s4_px_reg   <= px[Q_SHIFT +: 32];
            s4_py_reg   <= py[Q_SHIFT +: 32];
            out_reg     <= out_next;
        end
    end

    assign empty  = !out_vld_reg;
    assign result = out_reg;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !pop) |=> (out_vld_reg && $stable(out_reg)))
        else $error("result changed while stalled");
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.status != STATUS_OK) |->
        (out_reg.view_x == 0 && out_reg.view_y == 0 && out_reg.view_z == 0 &&
         out_reg.proj_x == 0 && out_reg.proj_y == 0))
        else $error("error result carries data");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.status == STATUS_OK || out_reg.status == STATUS_INVALID ||
                         out_reg.status == STATUS_OVERFLOW))
        else $error("undefined status code");
endmodule
`default_nettype wire

// File: design/camera_perspective_project_top.sv
// top level of the camera view transform and perspective projection block
//
// usage:
//   input channel: a vertex request (world x, y, z) is taken at a rising edge
//   with push high and full low. it lands in a four-entry queue, so the
//   sender keeps streaming while the back end is briefly held.
//   result channel: while empty is low the oldest result (status, view x/y/z,
//   screen x/y) sits on result; it is taken at an edge with pop high.
//   settings: cfg_we writes cfg_wdata into register cfg_addr (0 camera x,
//   1 camera y, 2 camera z, 3 forward, 4 right, 5 up axis, 6 near depth and
//   focal, 7 screen window); write only while no request is in flight.
// pipeline: the 31-stage reciprocal divider plus product, dot, depth, scale
//   and clamp stages lie between the queue and the result register.
// throughput: one request per cycle, sustained while results are popped.
// reset: rst_n clears all queues and valid bits and loads the default view
//   (camera at origin, identity axes, near 1, focal 160, 320x224-style window).
// stall: when the result is not popped the whole back pipeline holds; the
//   input queue then fills and full rises.
`timescale 1ns / 1ps
`default_nettype none
module camera_perspective_project_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_addr,
    input  wire logic [63:0]      cfg_wdata,
    input  wire logic             push,
    output logic                  full,
    input  wire cpp_pkg::vertex_t vertex,
    output logic                  empty,
    input  wire logic             pop,
    output cpp_pkg::result_t      result
);
    import cpp_pkg::*;

    cfg_t cfg;
    job_t job_in, job_out;
    logic job_wr, job_pop, job_empty;

    // front: settings and request classification
    cpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .vertex    (vertex),
        .job_wr    (job_wr),
        .job       (job_in),
        .cfg       (cfg)
    );

    // decoupling queue
    cpp_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH($bits(job_t))) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (full),
        .empty   (job_empty)
    );

    // back: arithmetic pipeline ending in the result register
    cpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (job_out),
        .job_ready (!job_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );
endmodule
`default_nettype wire

// File: bench/camera_perspective_project_top_test.sv
// testbench of the camera view transform and perspective projection block
`timescale 1ns / 1ps
module camera_perspective_project_top_test;
    import cpp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;
    localparam int PHASE_ITEMS    = 250;
    localparam int PHASE_COUNT    = 6;

    // dut ports, inputs all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [63:0] cfg_wdata = '0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    vertex_t     vertex    = '0;
    logic        full;
    logic        empty;
    result_t     result;

    // typed expectation set alongside each vertex request, kept off the dut ports
    logic        fixed_valid = 1'b0;
    result_t     fixed_result = '0;

    // settings as the block should hold them
    cfg_t        shadow_cfg;
    result_t     pending_results[$];

    int          error_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // long receiver hold-off: sender toggles, receiver counts on its own
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;

    // directed stimulus table: register writes and vertex requests
    typedef struct {
        bit          is_cfg;
        logic [2:0]  addr;
        logic [63:0] data;
        vertex_t     v;
        bit          has_exp;
        result_t     exp;
    } row_t;
    row_t        directed_rows[$];

    camera_perspective_project_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .vertex    (vertex),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // low 32 bits, sign extended back
    function automatic longint wrap32(longint x);
        logic [63:0] t;
        t = x;
        return longint'($signed(t[31:0]));
    endfunction

    // q16 dot product of the camera-relative vertex with one packed axis
    function automatic longint axis_dot(longint rx, longint ry, longint rz,
                                        logic [53:0] axis);
        longint ax, ay, az, sum;
        ax = longint'($signed(axis[17:0]));
        ay = longint'($signed(axis[35:18]));
        az = longint'($signed(axis[53:36]));
        sum = rx * ax + ry * ay + rz * az;
        return wrap32(sum >>> Q_SHIFT);
    endfunction

    function automatic result_t project_vertex(vertex_t v, cfg_t c);
        result_t r;
        longint near_d, focal, cx, cy, lo, hi;
        longint rx, ry, rz, vx, vy, vz, depth, recip, sx, sy;
        r = '0;
        near_d = longint'($signed(c.depth_and_focal[31:0]));
        focal  = longint'($signed(c.depth_and_focal[63:32]));
        cx = longint'($signed(c.screen_window[15:0]));
        cy = longint'($signed(c.screen_window[31:16]));
        lo = longint'($signed(c.screen_window[47:32]));
        hi = longint'($signed(c.screen_window[63:48]));
        // bad depth, focal or window: only the status is set
        if (near_d <= 0 || focal <= 0 || lo > hi)
        begin
            r.status = STATUS_INVALID;
            return r;
        end
        rx = wrap32(longint'(v.world_x) - longint'($signed(c.camera_x)));
        ry = wrap32(longint'(v.world_y) - longint'($signed(c.camera_y)));
        rz = wrap32(longint'(v.world_z) - longint'($signed(c.camera_z)));
        vz = axis_dot(rx, ry, rz, c.forward_axis);
        depth = (vz < near_d) ? near_d : vz;
        recip = (focal <<< Q_SHIFT) / depth;
        // reciprocal past 31 bits
        if (recip > 64'sh7FFF_FFFF)
        begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        vx = axis_dot(rx, ry, rz, c.right_axis);
        vy = axis_dot(rx, ry, rz, c.up_axis);
        sx = wrap32((recip * vx) >>> Q_SHIFT);
        sy = wrap32((recip * vy) >>> Q_SHIFT);
        // center sums wrap before the clamp
        sx = wrap32(cx + sx);
        sy = wrap32(cy - sy);
        sx = (sx < lo) ? lo : (sx > hi) ? hi : sx;
        sy = (sy < lo) ? lo : (sy > hi) ? hi : sy;
        r.status = STATUS_OK;
        r.view_x = vx[31:0];
        r.view_y = vy[31:0];
        r.view_z = vz[31:0];
        r.proj_x = sx[15:0];
        r.proj_y = sy[15:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard: requests in, results out, both seen at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (fixed_valid)
                    pending_results.push_back(fixed_result);
                else
                    pending_results.push_back(project_vertex(vertex, shadow_cfg));
            end
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: status %0d view %0d %0d %0d screen %0d %0d",
                                 result.status, result.view_x, result.view_y,
                                 result.view_z, result.proj_x, result.proj_y);
                end
                else
                begin
                    if (result !== pending_results[0])
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch: expected status %0d view %0d %0d %0d screen %0d %0d",
                                     pending_results[0].status, pending_results[0].view_x,
                                     pending_results[0].view_y, pending_results[0].view_z,
                                     pending_results[0].proj_x, pending_results[0].proj_y);
                            $display("          actual   status %0d view %0d %0d %0d screen %0d %0d",
                                     result.status, result.view_x, result.view_y,
                                     result.view_z, result.proj_x, result.proj_y);
                        end
                    end
                    void'(pending_results.pop_front());
                end
            end
        end
    end

    // watchdog: cycles with no request and no result accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus the long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            pop = 1'b0;
        else if (hold_left > 0)
        begin
            pop = 1'b0;
            hold_left--;
        end
        else
            pop = ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // sender side tasks, all entered and left just after a falling edge
    // ---------------------------------------------------------------
    task automatic send_vertex(vertex_t v, bit has_exp, result_t exp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        vertex = v;
        fixed_valid = has_exp;
        fixed_result = exp;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [63:0] data);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        // upper bits beyond each register's width drop off here
        case (addr)
            REG_CAMERA_X:      shadow_cfg.camera_x = data[31:0];
            REG_CAMERA_Y:      shadow_cfg.camera_y = data[31:0];
            REG_CAMERA_Z:      shadow_cfg.camera_z = data[31:0];
            REG_FORWARD_AXIS:  shadow_cfg.forward_axis = data[53:0];
            REG_RIGHT_AXIS:    shadow_cfg.right_axis = data[53:0];
            REG_UP_AXIS:       shadow_cfg.up_axis = data[53:0];
            REG_DEPTH_FOCAL:   shadow_cfg.depth_and_focal = data;
            REG_SCREEN_WINDOW: shadow_cfg.screen_window = data;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random axis: mostly components within one unit, sometimes any bits
    function automatic logic [53:0] rand_axis();
        logic [17:0] comp[3];
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(3) == 0)
                comp[i] = 18'($urandom);
            else
                comp[i] = 18'($urandom_range(131072) - 65536);
        end
        return {comp[2], comp[1], comp[0]};
    endfunction

    task automatic apply_random_setup();
        logic [31:0] near_d, focal;
        logic [15:0] cx, cy, lo, hi;
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(3) == 0)
                write_reg(REG_CAMERA_X + 3'(i), rand64());
            else
                write_reg(REG_CAMERA_X + 3'(i), 64'($urandom_range(20000)) - 64'd10000);
        end
        write_reg(REG_FORWARD_AXIS, {$urandom, $urandom});
        write_reg(REG_FORWARD_AXIS, {10'($urandom), rand_axis()});
        write_reg(REG_RIGHT_AXIS, {10'($urandom), rand_axis()});
        write_reg(REG_UP_AXIS, {10'($urandom), rand_axis()});
        // depth and focal: now and then raw bits, which can hit both error cases
        if ($urandom_range(7) == 0)
            write_reg(REG_DEPTH_FOCAL, rand64());
        else
        begin
            near_d = $urandom_range(1, 64);
            focal = $urandom_range(1, 4096);
            write_reg(REG_DEPTH_FOCAL, {focal, near_d});
        end
        if ($urandom_range(9) == 0)
            write_reg(REG_SCREEN_WINDOW, rand64());
        else
        begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            lo = 16'(-$urandom_range(2000));
            hi = 16'($urandom_range(2000));
            write_reg(REG_SCREEN_WINDOW, {hi, lo, cy, cx});
        end
    endtask

    // random vertex: mostly near the camera, the rest any bits
    function automatic vertex_t rand_vertex();
        vertex_t v;
        if ($urandom_range(9) < 7)
        begin
            v.world_x = shadow_cfg.camera_x + 32'($urandom_range(8192)) - 32'd4096;
            v.world_y = shadow_cfg.camera_y + 32'($urandom_range(8192)) - 32'd4096;
            v.world_z = shadow_cfg.camera_z + 32'($urandom_range(8192)) - 32'd1024;
        end
        else
        begin
            v.world_x = $urandom;
            v.world_y = $urandom;
            v.world_z = $urandom;
        end
        return v;
    endfunction

    function automatic void add_cfg(logic [2:0] addr, logic [63:0] data);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr = addr;
        r.data = data;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       bit has_exp, result_t exp);
        row_t r;
        r = '{default: '0};
        r.v = '{x, y, z};
        r.has_exp = has_exp;
        r.exp = exp;
        directed_rows.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        result_t none;
        result_t invalid_res;
        result_t overflow_res;
        none = '0;
        invalid_res = '0;
        invalid_res.status = STATUS_INVALID;
        overflow_res = '0;
        overflow_res.status = STATUS_OVERFLOW;

        shadow_cfg = '{32'd0, 32'd0, 32'd0, FORWARD_RESET, RIGHT_RESET, UP_RESET,
                       DEPTH_RESET, WINDOW_RESET};

        // default view: origin maps to the center, depth 100 keeps it there
        add_vertex(32'd0, 32'd0, 32'd0, 1,
                   '{STATUS_OK, 32'sd0, 32'sd0, 32'sd0, 16'sd160, 16'sd112});
        add_vertex(32'd0, 32'd0, 32'd100, 1,
                   '{STATUS_OK, 32'sd0, 32'sd0, 32'sd100, 16'sd160, 16'sd112});
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none);
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none);
        add_vertex(32'd1000, -32'sd1000, 32'd1, 0, none);
        add_vertex(-32'sd5, 32'd7, -32'sd3, 0, none);
        // camera at the extremes: relative coordinates wrap
        add_cfg(REG_CAMERA_X, 64'hFFFF_FFFF_8000_0000);
        add_cfg(REG_CAMERA_Y, 64'h0000_0000_7FFF_FFFF);
        add_cfg(REG_CAMERA_Z, 64'h0000_0000_0000_1234);
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 0, none);
        add_vertex(32'd0, 32'd0, 32'd0, 0, none);
        add_cfg(REG_CAMERA_X, 64'd0);
        add_cfg(REG_CAMERA_Y, 64'd0);
        add_cfg(REG_CAMERA_Z, 64'd0);
        // invalid settings: near zero, focal zero, near negative, window inverted
        add_cfg(REG_DEPTH_FOCAL, {32'd160, 32'd0});
        add_vertex(32'd1, 32'd2, 32'd3, 1, invalid_res);
        add_cfg(REG_DEPTH_FOCAL, {32'd0, 32'd1});
        add_vertex(32'd1, 32'd2, 32'd3, 1, invalid_res);
        add_cfg(REG_DEPTH_FOCAL, {32'h8000_0000, 32'hFFFF_FFFF});
        add_vertex(32'd1, 32'd2, 32'd3, 1, invalid_res);
        // reciprocal overflow: widest focal at unit depth
        add_cfg(REG_DEPTH_FOCAL, {32'h7FFF_FFFF, 32'd1});
        add_vertex(32'd4, 32'd4, 32'd0, 1, overflow_res);
        add_cfg(REG_SCREEN_WINDOW, {16'sd4, 16'sd5, 16'sd0, 16'sd0});
        add_vertex(32'd1, 32'd2, 32'd3, 1, invalid_res);
        // widest window with centers at the rails: center sums wrap
        add_cfg(REG_DEPTH_FOCAL, {32'd4096, 32'd1});
        add_cfg(REG_SCREEN_WINDOW, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
        add_vertex(32'h0100_0000, 32'hFF00_0000, 32'd0, 0, none);
        // extreme axes with junk in the unused upper bits
        add_cfg(REG_FORWARD_AXIS, {10'h3FF, 18'h20000, 18'h20000, 18'h20000});
        add_cfg(REG_RIGHT_AXIS, {10'h155, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
        add_cfg(REG_UP_AXIS, {10'h2AA, 18'h20000, 18'h1FFFF, 18'h20000});
        add_cfg(REG_DEPTH_FOCAL, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, none);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, none);
        // deepest near, smallest focal: reciprocal rounds to zero
        add_cfg(REG_DEPTH_FOCAL, {32'd1, 32'h7FFF_FFFF});
        add_vertex(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 0, none);

        // reset once, released just after a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                drain_results();
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            end
            else
                send_vertex(directed_rows[i].v, directed_rows[i].has_exp,
                            directed_rows[i].exp);
        end

        // random phases, each with fresh settings and one of four idling mixes
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            apply_random_setup();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // receiver holds off while requests keep coming: full must rise
                if (p == 0 && n == 40)
                    hold_toggle = ~hold_toggle;
                // sender waits until every result is back
                if (p == 1 && n == 120)
                    drain_results();
                send_vertex(rand_vertex(), 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
